// ===== design/crc_checked_packet_deframer_assert.svh =====
// Assertion macros shared by the deframer checker.
// Depends on nothing; each macro expands to one concurrent assertion.
`ifndef CRC_CHECKED_PACKET_DEFRAMER_ASSERT_SVH
`define CRC_CHECKED_PACKET_DEFRAMER_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define CDF_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define CDF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/cdf_pkg.sv =====
// Shared types and constants for the CRC checked packet deframer.
// Used by every module of the block; depends on nothing.
package cdf_pkg;

  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] CFG_SYNC_FIRST       = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SYNC_SECOND      = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_EXPECTED_VERSION = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_PAYLOAD      = 2'd3;

  localparam logic [7:0]  SYNC_FIRST_RST       = 8'hAA;
  localparam logic [7:0]  SYNC_SECOND_RST      = 8'h55;
  localparam logic [7:0]  EXPECTED_VERSION_RST = 8'h01;
  localparam logic [15:0] MAX_PAYLOAD_RST      = 16'd1024;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  typedef enum logic [1:0] {
    EV_NONE = 2'd0,
    EV_DATA = 2'd1,
    EV_GOOD = 2'd2,
    EV_ERR  = 2'd3
  } event_t;

  typedef enum logic [1:0] {
    ERR_NONE    = 2'd0,
    ERR_VERSION = 2'd1,
    ERR_LENGTH  = 2'd2,
    ERR_CRC     = 2'd3
  } err_t;

  typedef struct packed {
    logic [7:0]  sync_first;
    logic [7:0]  sync_second;
    logic [7:0]  expected_version;
    logic [15:0] max_payload;
  } cfg_t;

  typedef struct packed {
    event_t      event_res;
    logic [7:0]  data_byte;
    logic        last_payload;
    logic [7:0]  frame_type;
    logic [15:0] frame_length;
    err_t        error_code;
  } result_t;

endpackage

// ===== design/cdf_cfg_regs.sv =====
// Configuration register file of the deframer.
// Depends on cdf_pkg for register indexes, reset values and the cfg_t struct.
module cdf_cfg_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [cdf_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [cdf_pkg::CFG_DATA_W-1:0]      cfg_data,
  output cdf_pkg::cfg_t                       cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sync_first       <= cdf_pkg::SYNC_FIRST_RST;
      cfg.sync_second      <= cdf_pkg::SYNC_SECOND_RST;
      cfg.expected_version <= cdf_pkg::EXPECTED_VERSION_RST;
      cfg.max_payload      <= cdf_pkg::MAX_PAYLOAD_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        cdf_pkg::CFG_SYNC_FIRST:       cfg.sync_first       <= cfg_data[7:0];
        cdf_pkg::CFG_SYNC_SECOND:      cfg.sync_second      <= cfg_data[7:0];
        cdf_pkg::CFG_EXPECTED_VERSION: cfg.expected_version <= cfg_data[7:0];
        cdf_pkg::CFG_MAX_PAYLOAD:      cfg.max_payload      <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== design/cdf_crc_byte.sv =====
// One-byte update of CRC-16/CCITT-FALSE, MSB first, eight shift steps.
// Depends on cdf_pkg for the polynomial.
module cdf_crc_byte (
  input  logic [15:0] crc_in,
  input  logic [7:0]  data,
  output logic [15:0] crc_out
);

  always_comb begin
    logic [15:0] c;
    c = crc_in ^ {data, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ cdf_pkg::CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    crc_out = c;
  end

endmodule

// ===== design/cdf_parser.sv =====
// Frame parsing state machine: sync hunt, header, payload count and CRC check.
// Depends on cdf_pkg and cdf_crc_byte; produces one result per accepted byte.
module cdf_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  logic [7:0]        rx_byte,
  input  cdf_pkg::cfg_t     cfg,
  output cdf_pkg::result_t  res
);

  typedef enum logic [3:0] {
    PH_SYNC0   = 4'd0,
    PH_SYNC1   = 4'd1,
    PH_VERSION = 4'd2,
    PH_TYPE    = 4'd3,
    PH_LEN0    = 4'd4,
    PH_LEN1    = 4'd5,
    PH_PAYLOAD = 4'd6,
    PH_CRC0    = 4'd7,
    PH_CRC1    = 4'd8
  } phase_t;

  phase_t      phase, phase_next;
  logic [15:0] crc, crc_next;
  logic [7:0]  crc_low, crc_low_next;
  logic [15:0] length_expected, length_expected_next;
  logic [15:0] bytes_received, bytes_received_next;
  logic [7:0]  type_held, type_held_next;
  logic [15:0] crc_upd;
  logic [15:0] count_inc;
  logic [15:0] length_full;

  cdf_crc_byte u_crc (
    .crc_in  (crc),
    .data    (rx_byte),
    .crc_out (crc_upd)
  );

  assign count_inc   = bytes_received + 16'd1;
  assign length_full = {rx_byte, length_expected[7:0]};

  always_comb begin
    phase_next           = phase;
    crc_next             = crc;
    crc_low_next         = crc_low;
    length_expected_next = length_expected;
    bytes_received_next  = bytes_received;
    type_held_next       = type_held;
    res                  = '0;
    case (phase)
      PH_SYNC0: begin
        if (rx_byte == cfg.sync_first) begin
          phase_next = PH_SYNC1;
        end
      end
      PH_SYNC1: begin
        if (rx_byte == cfg.sync_second) begin
          phase_next           = PH_VERSION;
          crc_next             = cdf_pkg::CRC_INIT;
          bytes_received_next  = '0;
          length_expected_next = '0;
          type_held_next       = '0;
        end else begin
          phase_next = PH_SYNC0;
        end
      end
      PH_VERSION: begin
        if (rx_byte != cfg.expected_version) begin
          phase_next           = PH_SYNC0;
          crc_next             = cdf_pkg::CRC_INIT;
          crc_low_next         = '0;
          length_expected_next = '0;
          bytes_received_next  = '0;
          res.event_res        = cdf_pkg::EV_ERR;
          res.error_code       = cdf_pkg::ERR_VERSION;
        end else begin
          crc_next   = crc_upd;
          phase_next = PH_TYPE;
        end
      end
      PH_TYPE: begin
        type_held_next = rx_byte;
        crc_next       = crc_upd;
        phase_next     = PH_LEN0;
      end
      PH_LEN0: begin
        length_expected_next = {8'h00, rx_byte};
        crc_next             = crc_upd;
        phase_next           = PH_LEN1;
      end
      PH_LEN1: begin
        if (length_full > cfg.max_payload) begin
          phase_next           = PH_SYNC0;
          crc_next             = cdf_pkg::CRC_INIT;
          crc_low_next         = '0;
          length_expected_next = '0;
          bytes_received_next  = '0;
          res.event_res        = cdf_pkg::EV_ERR;
          res.error_code       = cdf_pkg::ERR_LENGTH;
        end else begin
          length_expected_next = length_full;
          crc_next             = crc_upd;
          phase_next           = (length_full == 16'd0) ? PH_CRC0 : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        crc_next            = crc_upd;
        bytes_received_next = count_inc;
        res.event_res       = cdf_pkg::EV_DATA;
        res.data_byte       = rx_byte;
        if (count_inc >= length_expected) begin
          res.last_payload = 1'b1;
          phase_next       = PH_CRC0;
        end
      end
      PH_CRC0: begin
        crc_low_next = rx_byte;
        phase_next   = PH_CRC1;
      end
      PH_CRC1: begin
        if ({rx_byte, crc_low} != crc) begin
          crc_next             = cdf_pkg::CRC_INIT;
          crc_low_next         = '0;
          length_expected_next = '0;
          bytes_received_next  = '0;
          res.event_res        = cdf_pkg::EV_ERR;
          res.error_code       = cdf_pkg::ERR_CRC;
        end else begin
          res.event_res    = cdf_pkg::EV_GOOD;
          res.frame_type   = type_held;
          res.frame_length = length_expected;
        end
        phase_next = PH_SYNC0;
      end
      default: begin
        phase_next           = PH_SYNC0;
        crc_next             = cdf_pkg::CRC_INIT;
        crc_low_next         = '0;
        length_expected_next = '0;
        bytes_received_next  = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_SYNC0;
      crc             <= cdf_pkg::CRC_INIT;
      crc_low         <= '0;
      length_expected <= '0;
      bytes_received  <= '0;
      type_held       <= '0;
    end else if (fire) begin
      phase           <= phase_next;
      crc             <= crc_next;
      crc_low         <= crc_low_next;
      length_expected <= length_expected_next;
      bytes_received  <= bytes_received_next;
      type_held       <= type_held_next;
    end
  end

endmodule

// ===== design/cdf_out_stage.sv =====
// Result register between the parser and the output channel.
// Depends on cdf_pkg for the result_t struct.
module cdf_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  cdf_pkg::result_t  res_in,
  input  logic              out_ready,
  output logic              out_valid,
  output logic              can_load,
  output cdf_pkg::result_t  res_out
);

  assign can_load = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_out <= res_in;
    end
  end

endmodule

// ===== design/crc_checked_packet_deframer.sv =====
// Top level of the CRC checked packet deframer.
// Depends on cdf_pkg, cdf_cfg_regs, cdf_parser, cdf_crc_byte and cdf_out_stage.
//
// Usage:
//   Input channel: rx_byte with in_valid / in_ready; one transaction per byte.
//   Output channel: one result transaction per input byte, carried on
//   event_res, data_byte, last_payload, frame_type, frame_length and
//   error_code with out_valid / out_ready.
//   Configuration: cfg_we writes cfg_data into register cfg_index
//   (0 sync_first, 1 sync_second, 2 expected_version, 3 max_payload);
//   write only while no transaction is in flight.
//   A result is registered: it appears the cycle after its byte is accepted.
//   Throughput: one byte per cycle unless the output stalls; the parser state
//   and the byte-wide CRC update are combinational, before the result register.
//   A stalled receiver holds the result register; in_ready then drops until
//   the pending result is taken, so no result is lost.
//   Reset: rst is synchronous; it restores the register defaults, puts the
//   parser in the sync hunt with the CRC at 0xFFFF and empties the output.
module crc_checked_packet_deframer (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [7:0]                       rx_byte,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [1:0]                       event_res,
  output logic [7:0]                       data_byte,
  output logic                             last_payload,
  output logic [7:0]                       frame_type,
  output logic [15:0]                      frame_length,
  output logic [1:0]                       error_code,
  input  logic                             cfg_we,
  input  logic [cdf_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [cdf_pkg::CFG_DATA_W-1:0]   cfg_data
);

  cdf_pkg::cfg_t    cfg;
  cdf_pkg::result_t res_comb;
  cdf_pkg::result_t res_reg;
  logic             fire;

  assign fire = in_valid && in_ready;

  cdf_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  cdf_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .fire    (fire),
    .rx_byte (rx_byte),
    .cfg     (cfg),
    .res     (res_comb)
  );

  cdf_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (fire),
    .res_in    (res_comb),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .can_load  (in_ready),
    .res_out   (res_reg)
  );

  assign event_res    = res_reg.event_res;
  assign data_byte    = res_reg.data_byte;
  assign last_payload = res_reg.last_payload;
  assign frame_type   = res_reg.frame_type;
  assign frame_length = res_reg.frame_length;
  assign error_code   = res_reg.error_code;

endmodule

// ===== design/cdf_checker.sv =====
// Port-level checker for the deframer, bound to the top level.
// Depends on crc_checked_packet_deframer_assert.svh and cdf_pkg.
`include "crc_checked_packet_deframer_assert.svh"

module cdf_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  event_res,
  input logic [7:0]  data_byte,
  input logic        last_payload,
  input logic [7:0]  frame_type,
  input logic [15:0] frame_length,
  input logic [1:0]  error_code
);

  logic        out_stall;
  logic [36:0] res;
  logic        not_data;
  logic        not_good;
  logic        data_clear;
  logic        good_clear;
  logic        err_match;

  assign out_stall  = out_valid && !out_ready;
  assign res        = {event_res, data_byte, last_payload, frame_type, frame_length, error_code};
  assign not_data   = out_valid && (event_res != cdf_pkg::EV_DATA);
  assign not_good   = out_valid && (event_res != cdf_pkg::EV_GOOD);
  assign data_clear = (data_byte == 8'h00) && !last_payload;
  assign good_clear = (frame_type == 8'h00) && (frame_length == 16'h0000);
  assign err_match  = (event_res == cdf_pkg::EV_ERR) == (error_code != cdf_pkg::ERR_NONE);

  `CDF_ASSERT_NEXT(a_out_hold, clk, rst, out_stall, out_valid && $stable(res), "result not held")
  `CDF_ASSERT_IMPLY(a_stall_blocks_input, clk, rst, out_stall, !in_ready, "input open in stall")
  `CDF_ASSERT_IMPLY(a_data_fields, clk, rst, not_data, data_clear, "stray payload fields")
  `CDF_ASSERT_IMPLY(a_good_fields, clk, rst, not_good, good_clear, "stray frame fields")
  `CDF_ASSERT_IMPLY(a_error_code, clk, rst, out_valid, err_match, "error code and event disagree")

endmodule

bind crc_checked_packet_deframer cdf_checker u_cdf_checker (.*);

// ===== sim/testbench.sv =====
// Self-checking testbench for crc_checked_packet_deframer, with random flow control.
// Builds framed byte streams, predicts each result and compares every field.
// Depends on cdf_pkg and the deframer RTL only.
module testbench;

  localparam int WATCHDOG_LIMIT = 2000;

  typedef enum logic [3:0] {
    HUNT_FIRST,
    HUNT_SECOND,
    GET_VERSION,
    GET_TYPE,
    GET_LEN_LO,
    GET_LEN_HI,
    GET_PAYLOAD,
    GET_CRC_LO,
    GET_CRC_HI
  } parse_phase_t;

  typedef enum logic [1:0] {
    READY_ALWAYS,
    READY_COIN,
    READY_PERIODIC,
    READY_STALL
  } ready_mode_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  logic [7:0]                      rx_byte = 8'h00;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  logic [1:0]                      event_res;
  logic [7:0]                      data_byte;
  logic                            last_payload;
  logic [7:0]                      frame_type;
  logic [15:0]                     frame_length;
  logic [1:0]                      error_code;
  logic                            cfg_we = 1'b0;
  logic [cdf_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [cdf_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

  logic [7:0]   want_sync_a;
  logic [7:0]   want_sync_b;
  logic [7:0]   want_version;
  logic [15:0]  payload_limit;
  parse_phase_t rx_phase;
  logic [15:0]  run_crc;
  logic [7:0]   crc_low;
  logic [15:0]  frame_len;
  logic [15:0]  payload_count;
  logic [7:0]   frame_kind;

  cdf_pkg::result_t expected_events[$];
  cdf_pkg::result_t want;
  logic [7:0]       frame_buf[$];
  int               failures = 0;
  int               bytes_sent = 0;
  int               burst_left = 0;
  int               quiet_cycles = 0;
  int               data_seen = 0;
  int               good_seen = 0;
  int               err_seen[4] = '{0, 0, 0, 0};
  ready_mode_t      ready_mode = READY_ALWAYS;
  int               ready_left = 0;

  crc_checked_packet_deframer dut (
    .clk, .rst, .in_valid, .in_ready, .rx_byte, .out_valid, .out_ready,
    .event_res, .data_byte, .last_payload, .frame_type, .frame_length, .error_code,
    .cfg_we, .cfg_index, .cfg_data
  );

  always #5 clk = ~clk;

  function automatic logic [15:0] crc16_update(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ((c << 1) ^ cdf_pkg::CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  function automatic void restart_hunt();
    rx_phase = HUNT_FIRST;
    run_crc = cdf_pkg::CRC_INIT;
    crc_low = 8'h00;
    frame_len = 16'h0000;
    payload_count = 16'h0000;
  endfunction

  function automatic void reset_predictor();
    want_sync_a = cdf_pkg::SYNC_FIRST_RST;
    want_sync_b = cdf_pkg::SYNC_SECOND_RST;
    want_version = cdf_pkg::EXPECTED_VERSION_RST;
    payload_limit = cdf_pkg::MAX_PAYLOAD_RST;
    restart_hunt();
    frame_kind = 8'h00;
  endfunction

  function automatic cdf_pkg::result_t deframe_step(logic [7:0] b);
    cdf_pkg::result_t r;
    logic [15:0] rx_crc;
    r = '0;
    r.event_res = cdf_pkg::EV_NONE;
    r.error_code = cdf_pkg::ERR_NONE;
    case (rx_phase)
      HUNT_FIRST: begin
        if (b == want_sync_a) rx_phase = HUNT_SECOND;
      end
      HUNT_SECOND: begin
        if (b == want_sync_b) begin
          rx_phase = GET_VERSION;
          run_crc = cdf_pkg::CRC_INIT;
          payload_count = 16'h0000;
          frame_len = 16'h0000;
          frame_kind = 8'h00;
        end else begin
          rx_phase = HUNT_FIRST;
        end
      end
      GET_VERSION: begin
        if (b != want_version) begin
          restart_hunt();
          r.event_res = cdf_pkg::EV_ERR;
          r.error_code = cdf_pkg::ERR_VERSION;
        end else begin
          run_crc = crc16_update(run_crc, b);
          rx_phase = GET_TYPE;
        end
      end
      GET_TYPE: begin
        frame_kind = b;
        run_crc = crc16_update(run_crc, b);
        rx_phase = GET_LEN_LO;
      end
      GET_LEN_LO: begin
        frame_len = {8'h00, b};
        run_crc = crc16_update(run_crc, b);
        rx_phase = GET_LEN_HI;
      end
      GET_LEN_HI: begin
        frame_len = {b, frame_len[7:0]};
        run_crc = crc16_update(run_crc, b);
        if (frame_len > payload_limit) begin
          restart_hunt();
          r.event_res = cdf_pkg::EV_ERR;
          r.error_code = cdf_pkg::ERR_LENGTH;
        end else begin
          rx_phase = (frame_len == 16'h0000) ? GET_CRC_LO : GET_PAYLOAD;
        end
      end
      GET_PAYLOAD: begin
        run_crc = crc16_update(run_crc, b);
        payload_count = payload_count + 16'd1;
        r.event_res = cdf_pkg::EV_DATA;
        r.data_byte = b;
        if (payload_count >= frame_len) begin
          r.last_payload = 1'b1;
          rx_phase = GET_CRC_LO;
        end
      end
      GET_CRC_LO: begin
        crc_low = b;
        rx_phase = GET_CRC_HI;
      end
      GET_CRC_HI: begin
        rx_crc = {b, crc_low};
        if (rx_crc != run_crc) begin
          restart_hunt();
          r.event_res = cdf_pkg::EV_ERR;
          r.error_code = cdf_pkg::ERR_CRC;
        end else begin
          r.event_res = cdf_pkg::EV_GOOD;
          r.frame_type = frame_kind;
          r.frame_length = frame_len;
          rx_phase = HUNT_FIRST;
        end
      end
      default: restart_hunt();
    endcase
    return r;
  endfunction

  function automatic void build_frame(logic [7:0] ver, logic [7:0] kind, logic [15:0] len,
                                      int n_payload, bit bad_crc);
    logic [15:0] crc;
    crc = cdf_pkg::CRC_INIT;
    frame_buf.delete();
    frame_buf.push_back(want_sync_a);
    frame_buf.push_back(want_sync_b);
    frame_buf.push_back(ver);
    frame_buf.push_back(kind);
    frame_buf.push_back(len[7:0]);
    frame_buf.push_back(len[15:8]);
    for (int i = 0; i < n_payload; i++) begin
      frame_buf.push_back(8'($urandom_range(0, 255)));
    end
    for (int i = 2; i < frame_buf.size(); i++) begin
      crc = crc16_update(crc, frame_buf[i]);
    end
    if (bad_crc) crc = crc ^ (16'h0001 << $urandom_range(0, 15));
    frame_buf.push_back(crc[7:0]);
    frame_buf.push_back(crc[15:8]);
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if ($urandom_range(0, 15) == 0) gap = $urandom_range(10, 20);
    end
    burst_left--;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    do @(posedge clk); while (!in_ready);
    expected_events.push_back(deframe_step(b));
    bytes_sent++;
  endtask

  task automatic send_frame(input int n_bytes);
    int n;
    n = (n_bytes < 0 || n_bytes > frame_buf.size()) ? frame_buf.size() : n_bytes;
    for (int i = 0; i < n; i++) begin
      send_byte(frame_buf[i]);
    end
  endtask

  task automatic set_reg(input logic [cdf_pkg::CFG_INDEX_W-1:0] idx, input logic [15:0] val);
    @(negedge clk);
    in_valid <= 1'b0;
    wait (expected_events.size() == 0);
    repeat (2) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      cdf_pkg::CFG_SYNC_FIRST:       want_sync_a = val[7:0];
      cdf_pkg::CFG_SYNC_SECOND:      want_sync_b = val[7:0];
      cdf_pkg::CFG_EXPECTED_VERSION: want_version = val[7:0];
      cdf_pkg::CFG_MAX_PAYLOAD:      payload_limit = val;
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [7:0] s1, input logic [7:0] s2,
                            input logic [7:0] ver, input logic [15:0] limit);
    set_reg(cdf_pkg::CFG_SYNC_FIRST, {8'h00, s1});
    set_reg(cdf_pkg::CFG_SYNC_SECOND, {8'h00, s2});
    set_reg(cdf_pkg::CFG_EXPECTED_VERSION, {8'h00, ver});
    set_reg(cdf_pkg::CFG_MAX_PAYLOAD, limit);
  endtask

  task automatic random_traffic(input int n);
    int stop;
    int pick;
    int lo;
    logic [15:0] len;
    logic [7:0] ver;
    stop = bytes_sent + n;
    while (bytes_sent < stop) begin
      pick = $urandom_range(0, 99);
      len = 16'(($urandom_range(0, 4) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8));
      if (len > payload_limit) len = payload_limit;
      if (pick < 65) begin
        build_frame(want_version, 8'($urandom_range(0, 255)), len, len, pick < 8);
        send_frame(-1);
      end else if (pick < 73) begin
        ver = 8'($urandom_range(0, 255));
        if (ver == want_version) ver = ~ver;
        build_frame(ver, 8'($urandom_range(0, 255)), len, 0, 1'b0);
        send_frame(3);
      end else if (pick < 81 && payload_limit != 16'hFFFF) begin
        lo = payload_limit + 1;
        build_frame(want_version, 8'($urandom_range(0, 255)),
                    16'($urandom_range(65535, lo)), 0, 1'b0);
        send_frame(6);
      end else if (pick < 90) begin
        build_frame(want_version, 8'($urandom_range(0, 255)), len, len, 1'b0);
        send_frame($urandom_range(1, frame_buf.size() - 1));
      end else begin
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
      end
    end
  endtask

  task automatic test_directed();
    send_byte(cdf_pkg::SYNC_FIRST_RST);
    send_byte(cdf_pkg::SYNC_FIRST_RST);
    send_byte(cdf_pkg::SYNC_SECOND_RST);
    build_frame(8'hFF, 8'h00, 16'h0000, 0, 1'b0);
    send_frame(3);
    build_frame(cdf_pkg::EXPECTED_VERSION_RST, 8'hFF, cdf_pkg::MAX_PAYLOAD_RST + 16'd1, 0,
                1'b0);
    send_frame(6);
    build_frame(cdf_pkg::EXPECTED_VERSION_RST, 8'h00, 16'h0000, 0, 1'b0);
    send_frame(-1);
    build_frame(cdf_pkg::EXPECTED_VERSION_RST, 8'hFF, 16'h0001, 1, 1'b1);
    send_frame(-1);
  endtask

  task automatic test_length_limit();
    set_config(cdf_pkg::SYNC_FIRST_RST, cdf_pkg::SYNC_SECOND_RST,
               cdf_pkg::EXPECTED_VERSION_RST, 16'h0000);
    build_frame(want_version, 8'h11, 16'h0000, 0, 1'b0);
    send_frame(-1);
    build_frame(want_version, 8'h12, 16'h0001, 0, 1'b0);
    send_frame(6);
    set_reg(cdf_pkg::CFG_MAX_PAYLOAD, 16'd3);
    build_frame(want_version, 8'h13, 16'd3, 3, 1'b0);
    send_frame(-1);
    build_frame(want_version, 8'h14, 16'd4, 0, 1'b0);
    send_frame(6);
    set_reg(cdf_pkg::CFG_MAX_PAYLOAD, 16'hFFFE);
    build_frame(want_version, 8'h15, 16'hFFFF, 0, 1'b0);
    send_frame(6);
    set_reg(cdf_pkg::CFG_MAX_PAYLOAD, 16'h7FFF);
    build_frame(want_version, 8'h16, 16'h8000, 0, 1'b0);
    send_frame(6);
    build_frame(want_version, 8'h17, 16'd2, 2, 1'b0);
    send_frame(-1);
  endtask

  task automatic test_sync_and_version();
    logic [7:0] settings[3][3];
    settings = '{'{8'h00, 8'hFF, 8'hFF}, '{8'hFF, 8'h00, 8'h00}, '{8'h5A, 8'h5A, 8'h80}};
    for (int s = 0; s < 3; s++) begin
      set_config(settings[s][0], settings[s][1], settings[s][2], 16'd64);
      build_frame(want_version, 8'($urandom_range(0, 255)), 16'd4, 4, 1'b0);
      send_frame(-1);
      build_frame(~want_version, 8'h00, 16'd0, 0, 1'b0);
      send_frame(3);
      random_traffic(50);
    end
  endtask

  task automatic test_random_traffic();
    set_config(cdf_pkg::SYNC_FIRST_RST, cdf_pkg::SYNC_SECOND_RST,
               cdf_pkg::EXPECTED_VERSION_RST, cdf_pkg::MAX_PAYLOAD_RST);
    random_traffic(150);
    set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
               8'($urandom_range(0, 255)), 16'hFFFF);
    random_traffic(150);
  endtask

  task automatic finish_run();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (expected_events.size() == 0);
    repeat (4) @(posedge clk);
    $display("Covered %0d received bytes over default, extreme and random register settings.",
             bytes_sent);
    $display("Checked %0d payload bytes, %0d good frames, %0d version, %0d length, %0d CRC errors.",
             data_seen, good_seen, err_seen[cdf_pkg::ERR_VERSION],
             err_seen[cdf_pkg::ERR_LENGTH], err_seen[cdf_pkg::ERR_CRC]);
    if (failures == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  endtask

  task automatic check_field(input string name, input logic [15:0] want_v,
                             input logic [15:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want_v, got_v);
      failures++;
    end
  endtask

  always @(negedge clk) begin
    if (ready_left == 0) begin
      ready_mode = ready_mode_t'($urandom_range(0, 3));
      ready_left = $urandom_range(4, 40);
    end
    ready_left--;
    case (ready_mode)
      READY_ALWAYS:   out_ready <= 1'b1;
      READY_COIN:     out_ready <= 1'($urandom_range(0, 1));
      READY_PERIODIC: out_ready <= (ready_left % 5 != 0);
      default:        out_ready <= (ready_left >= 25);
    endcase
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_events.size() == 0) begin
        $display("%0t: result transaction with none expected, actual event %h", $time,
                 event_res);
        failures++;
      end else begin
        want = expected_events.pop_front();
        check_field("event_res", 16'(want.event_res), 16'(event_res));
        check_field("data_byte", 16'(want.data_byte), 16'(data_byte));
        check_field("last_payload", 16'(want.last_payload), 16'(last_payload));
        check_field("frame_type", 16'(want.frame_type), 16'(frame_type));
        check_field("frame_length", want.frame_length, frame_length);
        check_field("error_code", 16'(want.error_code), 16'(error_code));
        case (want.event_res)
          cdf_pkg::EV_DATA: data_seen++;
          cdf_pkg::EV_GOOD: good_seen++;
          cdf_pkg::EV_ERR:  err_seen[want.error_code]++;
          default: ;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transaction for %0d cycles, %0d results outstanding", $time,
                 quiet_cycles, expected_events.size());
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    reset_predictor();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_length_limit();
    test_sync_and_version();
    test_random_traffic();
    finish_run();
  end

endmodule

// ===== filelist.f =====
+incdir+design
design/cdf_pkg.sv
design/cdf_cfg_regs.sv
design/cdf_crc_byte.sv
design/cdf_parser.sv
design/cdf_out_stage.sv
design/crc_checked_packet_deframer.sv
design/cdf_checker.sv
sim/testbench.sv
